>>> rtl/hrhs_pkg.sv
`default_nettype none

package hrhs_pkg;

    // Sizes
    localparam int TYPE_MAX      = 63;
    localparam int POSITION_BITS = 16;
    localparam int TYPE_ADDR_W   = $clog2(TYPE_MAX);
    localparam int TYPE_CNT_W    = $clog2(TYPE_MAX + 1);

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_beat_t;

    // One result beat
    typedef struct packed {
        logic signed [15:0] status_code;
        logic signed [31:0] content_length;
        logic               body_found;
        logic [15:0]        body_offset;
        logic [5:0]         type_length;
        logic [7:0]         type_char;
        logic [5:0]         type_char_index;
        logic               too_long;
        logic               last_result;
    } result_beat_t;

endpackage

`default_nettype wire

>>> rtl/http_response_header_scanner.sv
`default_nettype none

// Channel   Handshake                     Payload
// byte      byte_valid / byte_ready       byte_data  (hrhs_pkg::byte_beat_t)
// result    result_valid / result_ready   result     (hrhs_pkg::result_beat_t)
//
// Each byte beat updates all header state in the cycle in which it is accepted.
// After the beat marked last, one result beat per captured Content-Type byte
// (at least one) is issued at one per cycle, while the output is not stalled, from the
// 63-entry type memory, through a registered read stage and the output register.
// byte_ready is low while those reads are being issued, so a response holds off
// input after its last byte until the read of its last type byte has been issued.
// rst_n clears all control state asynchronously; the type memory is not cleared.
// A stalled result holds in the output register while the read stage fills behind it.

module http_response_header_scanner (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   byte_valid,
    output logic                  byte_ready,
    input  hrhs_pkg::byte_beat_t  byte_data,
    output logic                  result_valid,
    input  wire                   result_ready,
    output hrhs_pkg::result_beat_t result
);

    localparam int POS_W = hrhs_pkg::POSITION_BITS;
    localparam int CNT_W = hrhs_pkg::TYPE_CNT_W;
    localparam int ADR_W = hrhs_pkg::TYPE_ADDR_W;

    localparam logic [POS_W-1:0] POS_TOP = {POS_W{1'b1}};
    localparam logic [30:0]      LEN_TOP = {31{1'b1}};
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_0  = 8'd48;
    localparam logic [7:0] CH_9  = 8'd57;
    localparam logic [4:0] TYPE_NAME_LEN = 5'd13;
    localparam logic [4:0] LEN_NAME_LEN  = 5'd15;
    localparam logic [4:0] COL_TOP = 5'd31;

    typedef enum logic [3:0] {
        PH_SEEK_SPACE = 4'b0001,
        PH_IN_LINE    = 4'b0010,
        PH_LINE_START = 4'b0100,
        PH_DONE       = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        VM_IDLE        = 5'b00001,
        VM_TYPE_SPACES = 5'b00010,
        VM_TYPE_COPY   = 5'b00100,
        VM_LEN_SPACES  = 5'b01000,
        VM_LEN_DIGITS  = 5'b10000
    } vmode_t;

    // Header name bytes: bit 1 of idx picks Length, bit 0 picks all-lowercase
    function automatic logic [7:0] name_char(input logic [1:0] idx, input logic [4:0] col);
        logic [7:0] c;
        c = 8'h00;
        case (col)
            5'd0:  c = "c";
            5'd1:  c = "o";
            5'd2:  c = "n";
            5'd3:  c = "t";
            5'd4:  c = "e";
            5'd5:  c = "n";
            5'd6:  c = "t";
            5'd7:  c = "-";
            5'd8:  c = idx[1] ? "l" : "t";
            5'd9:  c = idx[1] ? "e" : "y";
            5'd10: c = idx[1] ? "n" : "p";
            5'd11: c = idx[1] ? "g" : "e";
            5'd12: c = idx[1] ? "t" : ":";
            5'd13: c = idx[1] ? "h" : 8'h00;
            5'd14: c = idx[1] ? ":" : 8'h00;
            default: c = 8'h00;
        endcase
        // exact-case names capitalize each word
        if (!idx[0] && (col == 5'd0 || col == 5'd8))
            c = c - 8'd32;
        return c;
    endfunction

    function automatic logic [4:0] name_len(input logic [1:0] idx);
        return idx[1] ? LEN_NAME_LEN : TYPE_NAME_LEN;
    endfunction

    // Scan state
    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      status_reg, status_next;
    logic [1:0]       seen_reg, seen_next;
    logic [4:0]       col_reg, col_next;
    logic [3:0]       cand_reg, cand_next;
    vmode_t           vm_reg, vm_next;
    logic [31:0]      len_reg, len_next;
    logic [30:0]      acc_reg, acc_next;
    logic [CNT_W-1:0] tc_reg, tc_next;
    logic [23:0]      recent_reg, recent_next;
    logic             crlf_found_reg, crlf_found_next;
    logic [POS_W-1:0] crlf_off_reg, crlf_off_next;
    logic             lf_found_reg, lf_found_next;
    logic [POS_W-1:0] lf_off_reg, lf_off_next;
    logic             ovf_reg, ovf_next;

    // Emit sequencer and output pipeline
    logic                   em_pend_reg;
    logic [ADR_W-1:0]       em_idx_reg;
    logic [CNT_W-1:0]       em_n_reg;
    hrhs_pkg::result_beat_t em_sum_reg;
    hrhs_pkg::result_beat_t summary;
    logic                   rd_valid_reg;
    hrhs_pkg::result_beat_t rd_meta_reg;
    logic [7:0]             rd_char_reg;
    logic                   out_valid_reg;
    hrhs_pkg::result_beat_t out_reg;

    logic [7:0] type_mem [hrhs_pkg::TYPE_MAX];

    logic             byte_fire;
    logic             issue;
    logic             rd_move;
    logic             wr_en;
    logic [ADR_W-1:0] wr_addr;
    logic [7:0]       b;
    logic [15:0]      diff;
    logic [15:0]      diff_x10;
    logic [15:0]      diff_x100;

    assign b          = byte_data.data_byte;
    assign byte_ready = !em_pend_reg;
    assign byte_fire  = byte_valid && byte_ready;

    // status digit terms, weight by shift-add
    assign diff      = {8'b0, b} - {8'b0, CH_0};
    assign diff_x10  = (diff << 3) + (diff << 1);
    assign diff_x100 = (diff << 6) + (diff << 5) + (diff << 2);

    // Per-byte scan
    always_comb
    begin
        logic [3:0]  keep;
        logic        name_end;
        logic [34:0] acc_mul;
        logic [15:0] term;

        keep     = '0;
        name_end = 1'b0;
        acc_mul  = '0;
        term     = '0;

        pos_next        = pos_reg;
        phase_next      = phase_reg;
        status_next     = status_reg;
        seen_next       = seen_reg;
        col_next        = col_reg;
        cand_next       = cand_reg;
        vm_next         = vm_reg;
        len_next        = len_reg;
        acc_next        = acc_reg;
        tc_next         = tc_reg;
        recent_next     = recent_reg;
        crlf_found_next = crlf_found_reg;
        crlf_off_next   = crlf_off_reg;
        lf_found_next   = lf_found_reg;
        lf_off_next     = lf_off_reg;
        ovf_next        = ovf_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        summary         = '0;

        if (byte_fire)
        begin
            // three status digits after the first space
            if (phase_reg != PH_SEEK_SPACE && seen_reg != 2'd3)
            begin
                case (seen_reg)
                    2'd0:    term = diff_x100;
                    2'd1:    term = diff_x10;
                    default: term = diff;
                endcase
                status_next = status_reg + term;
                seen_next   = seen_reg + 2'd1;
            end

            // header lines
            if (phase_reg == PH_SEEK_SPACE)
            begin
                if (b == CH_SP)
                    phase_next = PH_IN_LINE;
            end
            else if (phase_reg == PH_DONE)
            begin
                phase_next = PH_DONE;
            end
            else if (phase_reg == PH_LINE_START && (b == CH_CR || b == CH_LF))
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                if (phase_reg == PH_LINE_START)
                begin
                    phase_next = PH_IN_LINE;
                    cand_next  = 4'hF;
                    col_next   = '0;
                    vm_next    = VM_IDLE;
                end

                // name match at the line head
                if (cand_next != 4'h0)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (cand_next[i])
                        begin
                            if (col_next < name_len(2'(i)))
                            begin
                                if (b == name_char(2'(i), col_next))
                                    keep[i] = 1'b1;
                            end
                            else if (col_next == name_len(2'(i)))
                            begin
                                name_end = 1'b1;
                            end
                        end
                    end
                    if (name_end)
                    begin
                        keep = '0;
                        if (col_next == TYPE_NAME_LEN)
                        begin
                            tc_next = '0;
                            vm_next = VM_TYPE_SPACES;
                        end
                        else
                        begin
                            acc_next = '0;
                            len_next = '0;
                            vm_next  = VM_LEN_SPACES;
                        end
                    end
                    cand_next = keep;
                    if (col_next < COL_TOP)
                        col_next = col_next + 5'd1;
                end

                // header value
                if (vm_next == VM_TYPE_SPACES && b != CH_SP)
                    vm_next = VM_TYPE_COPY;
                if (vm_next == VM_LEN_SPACES && b != CH_SP)
                    vm_next = VM_LEN_DIGITS;
                if (vm_next == VM_TYPE_COPY)
                begin
                    if (b == CH_CR || b == CH_LF || tc_next >= CNT_W'(hrhs_pkg::TYPE_MAX))
                    begin
                        vm_next = VM_IDLE;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = tc_next[ADR_W-1:0];
                        tc_next = tc_next + 1'b1;
                    end
                end
                else if (vm_next == VM_LEN_DIGITS)
                begin
                    if (b >= CH_0 && b <= CH_9)
                    begin
                        acc_mul  = ({4'b0, acc_next} << 3) + ({4'b0, acc_next} << 1)
                                 + {27'b0, b - CH_0};
                        acc_next = (acc_mul > {4'b0, LEN_TOP}) ? LEN_TOP : acc_mul[30:0];
                        len_next = {1'b0, acc_next};
                    end
                    else
                    begin
                        vm_next = VM_IDLE;
                    end
                end

                if (b == CH_LF)
                begin
                    phase_next = PH_LINE_START;
                    cand_next  = '0;
                    vm_next    = VM_IDLE;
                end
            end

            // byte count and header end search
            if (pos_reg == POS_TOP)
                ovf_next = 1'b1;
            else
                pos_next = pos_reg + 1'b1;
            if (!ovf_next)
            begin
                if (!crlf_found_reg && recent_reg == 24'h0D0A0D && b == CH_LF)
                begin
                    crlf_found_next = 1'b1;
                    crlf_off_next   = pos_next;
                end
                if (!lf_found_reg && recent_reg[7:0] == CH_LF && b == CH_LF)
                begin
                    lf_found_next = 1'b1;
                    lf_off_next   = pos_next;
                end
            end
            recent_next = {recent_reg[15:0], b};

            // response summary and state clear on the last beat
            if (byte_data.last_byte)
            begin
                summary.status_code    = (seen_next == 2'd3) ? status_next : '0;
                summary.content_length = len_next;
                summary.type_length    = 6'(tc_next);
                summary.too_long       = ovf_next;
                if (crlf_found_next)
                begin
                    if (ovf_next || crlf_off_next < pos_next)
                    begin
                        summary.body_found  = 1'b1;
                        summary.body_offset = 16'(crlf_off_next);
                    end
                end
                else if (lf_found_next)
                begin
                    if (ovf_next || lf_off_next < pos_next)
                    begin
                        summary.body_found  = 1'b1;
                        summary.body_offset = 16'(lf_off_next);
                    end
                end

                pos_next        = '0;
                phase_next      = PH_SEEK_SPACE;
                status_next     = '0;
                seen_next       = '0;
                col_next        = '0;
                cand_next       = '0;
                vm_next         = VM_IDLE;
                len_next        = '1;
                acc_next        = '0;
                tc_next         = '0;
                recent_next     = '0;
                crlf_found_next = 1'b0;
                crlf_off_next   = '0;
                lf_found_next   = 1'b0;
                lf_off_next     = '0;
                ovf_next        = 1'b0;
            end
        end
    end

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= PH_SEEK_SPACE;
            status_reg     <= '0;
            seen_reg       <= '0;
            col_reg        <= '0;
            cand_reg       <= '0;
            vm_reg         <= VM_IDLE;
            len_reg        <= '1;
            acc_reg        <= '0;
            tc_reg         <= '0;
            recent_reg     <= '0;
            crlf_found_reg <= 1'b0;
            crlf_off_reg   <= '0;
            lf_found_reg   <= 1'b0;
            lf_off_reg     <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            status_reg     <= status_next;
            seen_reg       <= seen_next;
            col_reg        <= col_next;
            cand_reg       <= cand_next;
            vm_reg         <= vm_next;
            len_reg        <= len_next;
            acc_reg        <= acc_next;
            tc_reg         <= tc_next;
            recent_reg     <= recent_next;
            crlf_found_reg <= crlf_found_next;
            crlf_off_reg   <= crlf_off_next;
            lf_found_reg   <= lf_found_next;
            lf_off_reg     <= lf_off_next;
            ovf_reg        <= ovf_next;
        end
    end

    // Output pipeline moves
    assign rd_move = rd_valid_reg && (!out_valid_reg || result_ready);
    assign issue   = em_pend_reg && (!rd_valid_reg || rd_move);

    // Type byte memory: written by the scan, read by the emit sequencer
    always_ff @(posedge clk)
    begin
        if (wr_en)
            type_mem[wr_addr] <= b;
        if (issue)
            rd_char_reg <= type_mem[em_idx_reg];
    end

    // Emit sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_pend_reg <= 1'b0;
            em_idx_reg  <= '0;
        end
        else if (byte_fire && byte_data.last_byte)
        begin
            em_pend_reg <= 1'b1;
            em_idx_reg  <= '0;
        end
        else if (issue)
        begin
            if (CNT_W'(em_idx_reg) + 1'b1 >= em_n_reg)
            begin
                em_pend_reg <= 1'b0;
                em_idx_reg  <= '0;
            end
            else
            begin
                em_idx_reg <= em_idx_reg + 1'b1;
            end
        end
    end

    // Response summary snapshot
    always_ff @(posedge clk)
    begin
        if (byte_fire && byte_data.last_byte)
        begin
            em_sum_reg <= summary;
            em_n_reg   <= (summary.type_length == '0) ? CNT_W'(1) : CNT_W'(summary.type_length);
        end
    end

    // Read stage beat fields
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_meta_reg                 <= em_sum_reg;
            rd_meta_reg.type_char_index <= 6'(em_idx_reg);
            rd_meta_reg.last_result     <= (CNT_W'(em_idx_reg) + 1'b1 >= em_n_reg);
        end
    end

    // Output register beat fields
    always_ff @(posedge clk)
    begin
        if (rd_move)
        begin
            out_reg           <= rd_meta_reg;
            out_reg.type_char <= (rd_meta_reg.type_length == '0) ? 8'h00 : rd_char_reg;
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
                rd_valid_reg <= 1'b1;
            else if (rd_move)
                rd_valid_reg <= 1'b0;
            if (rd_move)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

>>> rtl/hrhs_checker.sv
`default_nettype none

module hrhs_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    byte_valid,
    input wire                    byte_ready,
    input hrhs_pkg::byte_beat_t   byte_data,
    input wire                    result_valid,
    input wire                    result_ready,
    input hrhs_pkg::result_beat_t result
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // a response with no type bytes gives one beat, marked last, with zero type index and char
    a_empty_type: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.type_length == 6'd0 |->
            result.last_result && result.type_char_index == 6'd0 && result.type_char == 8'h00)
        else $error("empty type response beat malformed");

    // index stays inside the captured type, and last marks its end
    a_type_index: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.type_length != 6'd0 |->
            result.type_char_index < result.type_length &&
            result.last_result == (result.type_char_index + 6'd1 == result.type_length))
        else $error("type index or last marker out of step");

    // body offset is zero without a body
    a_body_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.body_found |-> result.body_offset == 16'd0)
        else $error("body offset set without body");

    // consecutive beats of one response count up by one
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_result ##1 result_valid |->
            result.type_char_index == $past(result.type_char_index) + 6'd1)
        else $error("type index skipped");

endmodule

bind http_response_header_scanner hrhs_checker u_hrhs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

>>> tb/testbench.sv
module testbench;

    import hrhs_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 430;
    localparam int POS_LIMIT    = (1 << POSITION_BITS) - 1;
    localparam int TYPE_NAMES   = 2;
    localparam int LEN_TOP      = 2147483647;

    localparam logic [7:0] CR    = 8'h0D;
    localparam logic [7:0] LF    = 8'h0A;
    localparam logic [7:0] SPACE = 8'h20;
    localparam logic [7:0] ZERO  = 8'h30;
    localparam logic [7:0] NINE  = 8'h39;

    typedef enum logic [1:0] {SEEK_SPACE, IN_LINE, LINE_START, HEADERS_DONE} scan_phase_e;
    typedef enum logic [2:0] {
        VALUE_IDLE, TYPE_SPACES, TYPE_COPY, LENGTH_SPACES, LENGTH_DIGITS
    } value_mode_e;

    // One directed response: head text, a run of one repeated byte, tail text.
    // Rows marked typed carry the whole summary (single beat, no type bytes).
    typedef struct {
        string      head;
        int         pad_count;
        logic [7:0] pad_value;
        string      tail;
        bit         typed;
        int         status;
        int         length;
        bit         found;
        int         offset;
        bit         overflowed;
    } stim_row_t;

    typedef struct {
        bit           typed;
        result_beat_t beat;
    } response_check_t;

    localparam int DIRECTED_ROWS = 17;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{"HTTP/1.1 200 OK\015\n\015\nX", 0, 8'h00, "", 1, 200, -1, 1, 19, 0},
        '{"Z", 0, 8'h00, "", 1, 0, -1, 0, 0, 0},
        '{"A \377\377\377", 0, 8'h00, "", 1, 22977, -1, 0, 0, 0},
        '{"A ", 3, 8'h00, "", 1, -5328, -1, 0, 0, 0},
        '{"HTTP/1.1 200 OK\015\nContent-Length: 99999999999\015\n\015\nB", 0, 8'h00, "",
          1, 200, 2147483647, 1, 48, 0},
        '{"HTTP/1.1 404 Not Found\ncontent-length:\n\nZ", 0, 8'h00, "",
          1, 404, 0, 1, 40, 0},
        '{"HTTP/1.1 200 OK\015\nContent-Type: text/html\015\ncontent-type:\015\n\015\nQ",
          0, 8'h00, "", 1, 200, -1, 1, 59, 0},
        '{"HTTP/1.0 301 X\n\nbody\015\n\015\n", 0, 8'h00, "", 1, 301, -1, 0, 0, 0},
        '{"HTTP/1.1 200 OK\015\nContent-Type:   text/plain; charset=utf-8\015\n",
          0, 8'h00, "Content-Length: 1234\015\n\015\n<html>", 0, 0, 0, 0, 0, 0},
        '{"HTTP/1.1 200 OK\015\ncontent-type: ", 70, 8'h78, "\015\n\015\nb",
          0, 0, 0, 0, 0, 0},
        '{"HTTP/1.0 500 E\nCONTENT-TYPE: a\n Content-Length: 7\ncontent-length: 12ab\n\nzz",
          0, 8'h00, "", 0, 0, 0, 0, 0, 0},
        '{"HTTP/1.1 204 N\015\nContent-Length:", 0, 8'h00, "", 0, 0, 0, 0, 0, 0},
        '{"HTTP/1.1 200 OK\nContent-Type:x", 0, 8'h00, "", 0, 0, 0, 0, 0, 0},
        '{"HTTP/1.1 200 OK\nContent-Length: 5\nContent-Length: 9\n\nContent-Length: 3\n",
          0, 8'h00, "body", 0, 0, 0, 0, 0, 0},
        '{"Content-Type: abc\nContent-Type: def\n\n!", 0, 8'h00, "", 0, 0, 0, 0, 0, 0},
        '{"HTTP/1.1 200 OK\ncontent-type:", 63, 8'hFF, "\n\n", 0, 0, 0, 0, 0, 0},
        '{"HTTP/1.1 200 OK\015\n\015\n", 65530, 8'h61, "b", 1, 200, -1, 1, 19, 1}
    };

    // Header end arriving only after the position counter saturated
    stim_row_t late_end_row = '{"HTTP/1.1 200 OK\015\n", 65530, 8'h61, "\015\n\015\nz",
                                1, 200, -1, 0, 0, 1};

    string header_names [4] = '{"Content-Type:", "content-type:",
                                "Content-Length:", "content-length:"};

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         byte_valid   = 1'b0;
    logic         byte_ready;
    byte_beat_t   byte_data    = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    result_beat_t result;

    byte_beat_t      byte_stream [$];
    response_check_t response_checks [$];
    result_beat_t    expected_summary_beats [$];

    int bytes_total    = 0;
    int bytes_accepted = 0;
    int failure_count  = 0;
    int quiet_cycles   = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int stall_left     = 0;
    logic [8:0] ready_tick = '0;

    // Scanner state mirrored by the predictor
    int          byte_count;
    scan_phase_e phase;
    int          status_acc;
    int          status_digits;
    int          line_col;
    logic [3:0]  name_hits;
    value_mode_e vmode;
    longint      clen_value;
    longint      clen_acc;
    logic [7:0]  ctype_bytes [TYPE_MAX];
    int          ctype_count;
    logic [23:0] recent;
    bit          crlf_seen;
    int          crlf_at;
    bit          lflf_seen;
    int          lflf_at;
    bit          pos_overflow;

    http_response_header_scanner i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic void clear_scan_state();
        byte_count    = 0;
        phase         = SEEK_SPACE;
        status_acc    = 0;
        status_digits = 0;
        line_col      = 0;
        name_hits     = '0;
        vmode         = VALUE_IDLE;
        clen_value    = -1;
        clen_acc      = 0;
        foreach (ctype_bytes[i])
            ctype_bytes[i] = '0;
        ctype_count   = 0;
        recent        = '0;
        crlf_seen     = 1'b0;
        crlf_at       = 0;
        lflf_seen     = 1'b0;
        lflf_at       = 0;
        pos_overflow  = 1'b0;
    endfunction

    // Column-0 name match; a name fires on the byte after its colon
    function automatic void match_header_name(logic [7:0] b);
        logic [3:0] keep;
        keep = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (name_hits[i])
            begin
                if (line_col < header_names[i].len())
                begin
                    if (b == header_names[i][line_col])
                        keep[i] = 1'b1;
                end
                else if (line_col == header_names[i].len())
                begin
                    if (i < TYPE_NAMES)
                    begin
                        ctype_count = 0;
                        vmode       = TYPE_SPACES;
                    end
                    else
                    begin
                        clen_acc   = 0;
                        clen_value = 0;
                        vmode      = LENGTH_SPACES;
                    end
                    keep = '0;
                    break;
                end
            end
        end
        name_hits = keep;
        if (line_col < 31)
            line_col++;
    endfunction

    function automatic void take_value_byte(logic [7:0] b);
        longint next_acc;
        if (vmode == TYPE_SPACES)
        begin
            if (b == SPACE)
                return;
            vmode = TYPE_COPY;
        end
        if (vmode == TYPE_COPY)
        begin
            if (b == CR || b == LF || ctype_count >= TYPE_MAX)
                vmode = VALUE_IDLE;
            else
            begin
                ctype_bytes[ctype_count] = b;
                ctype_count++;
            end
            return;
        end
        if (vmode == LENGTH_SPACES)
        begin
            if (b == SPACE)
                return;
            vmode = LENGTH_DIGITS;
        end
        if (vmode == LENGTH_DIGITS)
        begin
            if (b >= ZERO && b <= NINE)
            begin
                next_acc   = clen_acc * 10 + (b - ZERO);
                clen_acc   = (next_acc > LEN_TOP) ? LEN_TOP : next_acc;
                clen_value = clen_acc;
            end
            else
                vmode = VALUE_IDLE;
        end
    endfunction

    function automatic void scan_header_byte(logic [7:0] b);
        if (phase == SEEK_SPACE)
        begin
            if (b == SPACE)
                phase = IN_LINE;
            return;
        end
        if (phase == HEADERS_DONE)
            return;
        if (phase == LINE_START)
        begin
            if (b == CR || b == LF)
            begin
                phase = HEADERS_DONE;
                return;
            end
            phase     = IN_LINE;
            name_hits = 4'hF;
            line_col  = 0;
            vmode     = VALUE_IDLE;
        end
        if (name_hits != 0)
            match_header_name(b);
        if (vmode != VALUE_IDLE)
            take_value_byte(b);
        if (b == LF)
        begin
            phase     = LINE_START;
            name_hits = '0;
            vmode     = VALUE_IDLE;
        end
    endfunction

    // Advance the scanner by one accepted byte; on the last byte queue the summary beats
    function automatic void scan_response_byte(logic [7:0] b, logic last);
        response_check_t check;
        result_beat_t    beat;
        int              beats;
        bit              found;
        int              offs;
        if (phase != SEEK_SPACE && status_digits < 3)
        begin
            status_acc += (int'(b) - 48) *
                          ((status_digits == 0) ? 100 : (status_digits == 1) ? 10 : 1);
            status_digits++;
        end
        scan_header_byte(b);

        if (byte_count >= POS_LIMIT)
            pos_overflow = 1'b1;
        else
            byte_count++;
        if (!pos_overflow)
        begin
            if (!crlf_seen && recent == {CR, LF, CR} && b == LF)
            begin
                crlf_seen = 1'b1;
                crlf_at   = byte_count;
            end
            if (!lflf_seen && recent[7:0] == LF && b == LF)
            begin
                lflf_seen = 1'b1;
                lflf_at   = byte_count;
            end
        end
        recent = {recent[15:0], b};

        if (!last)
            return;

        found = 1'b0;
        offs  = 0;
        if (crlf_seen)
        begin
            if (pos_overflow || crlf_at < byte_count)
            begin
                found = 1'b1;
                offs  = crlf_at;
            end
        end
        else if (lflf_seen)
        begin
            if (pos_overflow || lflf_at < byte_count)
            begin
                found = 1'b1;
                offs  = lflf_at;
            end
        end

        check = response_checks.pop_front();
        if (check.typed)
            expected_summary_beats.push_back(check.beat);
        else
        begin
            beats = (ctype_count != 0) ? ctype_count : 1;
            for (int k = 0; k < beats; k++)
            begin
                beat                 = '0;
                beat.status_code     = (status_digits == 3) ? status_acc[15:0] : 16'sd0;
                beat.content_length  = clen_value[31:0];
                beat.body_found      = found;
                beat.body_offset     = 16'(offs);
                beat.type_length     = 6'(ctype_count);
                beat.type_char       = (ctype_count != 0) ? ctype_bytes[k] : 8'h00;
                beat.type_char_index = 6'(k);
                beat.too_long        = pos_overflow;
                beat.last_result     = (k == beats - 1);
                expected_summary_beats.push_back(beat);
            end
        end
        clear_scan_state();
    endfunction

    task automatic report_failure(string msg);
        if (failure_count < 50)
            $display("ERROR at %0t: %s", $realtime, msg);
        failure_count++;
    endtask

    task automatic check_summary_beat(result_beat_t got);
        result_beat_t want;
        if (expected_summary_beats.size() == 0)
        begin
            report_failure($sformatf("result beat with nothing expected, index %0d",
                                     got.type_char_index));
            return;
        end
        want = expected_summary_beats.pop_front();
        if (got.status_code !== want.status_code)
            report_failure($sformatf("status_code %0d, expected %0d",
                                     got.status_code, want.status_code));
        if (got.content_length !== want.content_length)
            report_failure($sformatf("content_length %0d, expected %0d",
                                     got.content_length, want.content_length));
        if (got.body_found !== want.body_found)
            report_failure($sformatf("body_found %0d, expected %0d",
                                     got.body_found, want.body_found));
        if (got.body_offset !== want.body_offset)
            report_failure($sformatf("body_offset %0d, expected %0d",
                                     got.body_offset, want.body_offset));
        if (got.type_length !== want.type_length)
            report_failure($sformatf("type_length %0d, expected %0d",
                                     got.type_length, want.type_length));
        if (got.type_char !== want.type_char)
            report_failure($sformatf("type_char %0d, expected %0d",
                                     got.type_char, want.type_char));
        if (got.type_char_index !== want.type_char_index)
            report_failure($sformatf("type_char_index %0d, expected %0d",
                                     got.type_char_index, want.type_char_index));
        if (got.too_long !== want.too_long)
            report_failure($sformatf("too_long %0d, expected %0d",
                                     got.too_long, want.too_long));
        if (got.last_result !== want.last_result)
            report_failure($sformatf("last_result %0d, expected %0d",
                                     got.last_result, want.last_result));
    endtask

    function automatic void append_text(ref logic [7:0] bytes [$], input string s);
        for (int i = 0; i < s.len(); i++)
            bytes.push_back(s[i]);
    endfunction

    // Raw byte, biased toward the line and field separators
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return CR;
            1:       return LF;
            2:       return SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_response(ref logic [7:0] bytes [$], input bit typed,
                                           input result_beat_t beat);
        byte_beat_t      b;
        response_check_t check;
        foreach (bytes[i])
        begin
            b.data_byte = bytes[i];
            b.last_byte = (i == bytes.size() - 1);
            byte_stream.push_back(b);
        end
        check.typed = typed;
        check.beat  = beat;
        response_checks.push_back(check);
        bytes_total += bytes.size();
    endfunction

    function automatic void queue_row(stim_row_t row);
        logic [7:0]   text [$];
        result_beat_t want;
        append_text(text, row.head);
        repeat (row.pad_count)
            text.push_back(row.pad_value);
        append_text(text, row.tail);
        want                = '0;
        want.status_code    = 16'(row.status);
        want.content_length = 32'(row.length);
        want.body_found     = row.found;
        want.body_offset    = 16'(row.offset);
        want.too_long       = row.overflowed;
        want.last_result    = 1'b1;
        queue_response(text, row.typed, want);
    endfunction

    // Mostly a status line plus header lines with random content; some pure noise,
    // some cut short anywhere
    function automatic void make_random_response(ref logic [7:0] bytes [$]);
        string eol;
        int    n;
        int    pick;
        bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 24);
            repeat (n)
                bytes.push_back(noise_byte());
            return;
        end
        eol = ($urandom_range(0, 1) != 0) ? "\015\n" : "\n";
        append_text(bytes, "HTTP/1.1 ");
        repeat (3)
            bytes.push_back(($urandom_range(0, 7) == 0) ? noise_byte()
                                                        : 8'(ZERO + $urandom_range(0, 9)));
        append_text(bytes, " OK");
        append_text(bytes, eol);
        repeat ($urandom_range(0, 3))
        begin
            pick = $urandom_range(0, 6);
            case (pick)
                4:       append_text(bytes, "Content-Lenght:");
                5:       append_text(bytes, "Content-type:");
                6:       append_text(bytes, "X-Tag:");
                default: append_text(bytes, header_names[pick]);
            endcase
            repeat ($urandom_range(0, 2))
                bytes.push_back(SPACE);
            if (pick == 2 || pick == 3)
            begin
                repeat ($urandom_range(0, 12))
                    bytes.push_back(8'(ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 3) == 0)
                    bytes.push_back(8'h6B);
            end
            else
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 80)
                                                 : $urandom_range(0, 10);
                repeat (n)
                    bytes.push_back(($urandom_range(0, 7) == 0) ? noise_byte()
                                                                : 8'($urandom_range(33, 126)));
            end
            append_text(bytes, eol);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            append_text(bytes, eol);
            repeat ($urandom_range(0, 5))
                bytes.push_back(noise_byte());
        end
        if ($urandom_range(0, 5) == 0)
        begin
            n     = $urandom_range(1, bytes.size());
            bytes = bytes[0:n-1];
        end
    endfunction

    // Byte sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            byte_valid <= 1'b0;
        else if (!byte_valid || byte_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                byte_valid <= 1'b0;
            end
            else if (byte_stream.size() > 0)
            begin
                byte_data  <= byte_stream.pop_front();
                byte_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Result receiver: starts stalls only while bit 8 of ready_tick is set
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            ready_tick <= ready_tick + 1'b1;
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (ready_tick[8] && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Beat monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                scan_response_byte(byte_data.data_byte, byte_data.last_byte);
                bytes_accepted++;
            end
            if (result_valid && result_ready)
                check_summary_beat(result);
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0]   text [$];
        result_beat_t none;
        int           random_bytes;

        clear_scan_state();
        none = '0;
        foreach (directed_rows[r])
            queue_row(directed_rows[r]);
        queue_row(late_end_row);

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            make_random_response(text);
            random_bytes += text.size();
            queue_response(text, 1'b0, none);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted != bytes_total || expected_summary_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failure_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hrhs_pkg.sv
rtl/http_response_header_scanner.sv
rtl/hrhs_checker.sv
tb/testbench.sv
